// ===== hw/rtl/button_gesture_classifier_top_assert.svh =====
// Assertion macros shared by the button gesture classifier RTL.
`ifndef BUTTON_GESTURE_CLASSIFIER_TOP_ASSERT_SVH
`define BUTTON_GESTURE_CLASSIFIER_TOP_ASSERT_SVH

// Checks that a condition implies another in the same cycle.
`define BGC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies another in the following cycle.
`define BGC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bgc_pkg.sv =====
// Types and constants of the button gesture classifier.
package bgc_pkg;

    localparam int unsigned NUM_BUTTONS = 3;

    localparam logic [15:0] LONG_PRESS_RESET   = 16'd1000;
    localparam logic [15:0] DOUBLE_CLICK_RESET = 16'd300;

    // Configuration register indexes (byte address = 4 * index).
    localparam logic [1:0] REG_LONG_PRESS   = 2'd0;
    localparam logic [1:0] REG_DOUBLE_CLICK = 2'd1;
    localparam logic [1:0] REG_DISPLAY_FLIP = 2'd2;

    // Per-button phase; reset sorts below idle.
    typedef enum logic [2:0] {
        PH_RESET       = 3'd0,
        PH_IDLE        = 3'd1,
        PH_FIRST_DOWN  = 3'd2,
        PH_WAITING     = 3'd3,
        PH_SECOND_DOWN = 3'd4,
        PH_HELD        = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_PRESS    = 3'd1,
        EV_CLICK    = 3'd2,
        EV_DOUBLE   = 3'd3,
        EV_LONG     = 3'd4,
        EV_RELEASED = 3'd5
    } event_t;

    // Status of one button after the current word has been applied.
    typedef struct packed {
        logic held;
        logic in_reset;
        logic busy;
    } btn_status_t;

    typedef struct packed {
        logic [2:0] event_left;
        logic [2:0] event_middle;
        logic [2:0] event_right;
        logic [2:0] held_flags;
        logic [2:0] reset_flags;
        logic       lock_request;
    } result_word_t;

endpackage

// ===== hw/rtl/bgc_if.sv =====
// Channel interfaces for the sample and result words.
interface bgc_sample_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic        switch_one;
    logic        switch_two;
    logic        switch_three;
    logic [31:0] time_ms;

    modport source (
        output valid, mode, switch_one, switch_two, switch_three, time_ms,
        input  ready
    );
    modport sink (
        input  valid, mode, switch_one, switch_two, switch_three, time_ms,
        output ready
    );
endinterface

interface bgc_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_left;
    logic [2:0] event_middle;
    logic [2:0] event_right;
    logic [2:0] held_flags;
    logic [2:0] reset_flags;
    logic       lock_request;

    modport source (
        output valid, event_left, event_middle, event_right, held_flags,
               reset_flags, lock_request,
        input  ready
    );
    modport sink (
        input  valid, event_left, event_middle, event_right, held_flags,
               reset_flags, lock_request,
        output ready
    );
endinterface

// ===== hw/rtl/bgc_button.sv =====
// Gesture state machine for a single push button.
module bgc_button
    import bgc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic        clear,
    input  logic        level,
    input  logic [31:0] now,
    input  logic [15:0] long_press_ms,
    input  logic [15:0] double_click_ms,
    output event_t      evt,
    output btn_status_t status
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [31:0] start_reg;
    logic [31:0] start_next;
    logic [31:0] elapsed;
    logic        long_hit;
    logic        dbl_early;
    logic        dbl_expired;

    // Time since the phase started, modulo 2^32.
    assign elapsed     = now - start_reg;
    assign long_hit    = elapsed > {16'd0, long_press_ms};
    assign dbl_early   = elapsed < {16'd0, double_click_ms};
    assign dbl_expired = elapsed > {16'd0, double_click_ms};

    always_comb
    begin
        phase_next = phase_reg;
        start_next = start_reg;
        if (clear)
        begin
            phase_next = PH_RESET;
        end
        else if (step)
        begin
            case (phase_reg)
                PH_RESET:
                begin
                    if (!level)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_IDLE:
                begin
                    if (level)
                    begin
                        phase_next = PH_FIRST_DOWN;
                        start_next = now;
                    end
                end
                PH_FIRST_DOWN:
                begin
                    if (level)
                    begin
                        if (long_hit)
                        begin
                            phase_next = PH_HELD;
                        end
                    end
                    else
                    begin
                        phase_next = PH_WAITING;
                        start_next = now;
                    end
                end
                PH_WAITING:
                begin
                    if (level)
                    begin
                        if (dbl_early)
                        begin
                            phase_next = PH_SECOND_DOWN;
                        end
                        else
                        begin
                            phase_next = PH_FIRST_DOWN;
                            start_next = now;
                        end
                    end
                    else if (dbl_expired)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_SECOND_DOWN:
                begin
                    if (!level)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_HELD:
                begin
                    if (!level)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        evt = EV_NONE;
        if (step && !clear)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (level)
                    begin
                        evt = EV_PRESS;
                    end
                end
                PH_FIRST_DOWN:
                begin
                    if (level)
                    begin
                        if (long_hit)
                        begin
                            evt = EV_LONG;
                        end
                    end
                    else
                    begin
                        evt = EV_CLICK;
                    end
                end
                PH_WAITING:
                begin
                    if (level)
                    begin
                        evt = dbl_early ? EV_DOUBLE : EV_PRESS;
                    end
                end
                PH_HELD:
                begin
                    if (!level)
                    begin
                        evt = EV_RELEASED;
                    end
                end
                default:
                begin
                    evt = EV_NONE;
                end
            endcase
        end
    end

    assign status.held     = (phase_next == PH_HELD);
    assign status.in_reset = (phase_next == PH_RESET);
    assign status.busy     = (phase_next > PH_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            start_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            start_reg <= start_next;
        end
    end

endmodule

// ===== hw/rtl/button_gesture_classifier_top.sv =====
// Top level of the three-button gesture classifier with its register port.
//
// Usage: each word on the sample channel either carries three switch levels
// with a millisecond tick (mode 0) or orders all buttons into the reset
// phase (mode 1). Every accepted sample word yields exactly one result word
// with one event code per button (left, middle, right), the held and
// in-reset flags and the lock request, all taken after the word is applied.
// Throughput is one word per cycle while the skid register is empty; the
// three per-button state machines each close one subtract and compare per
// cycle. The result channel has an output register and one skid register,
// so a new sample word is still taken while a finished result waits; only
// when both hold words does sample.ready drop. Results leave in order.
// Reset clears both output stages, puts every button in the idle phase with
// a start time of zero, and loads the register defaults (long press 1000 ms,
// double click 300 ms, no flip). The user must write the APB port only
// while idle; the block does not enforce it.
`include "button_gesture_classifier_top_assert.svh"

module button_gesture_classifier_top
    import bgc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    bgc_sample_if.sink          sample,
    bgc_result_if.source        result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // Configuration registers.
    logic [15:0] long_press_reg;
    logic [15:0] double_click_reg;
    logic        display_flip_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg   <= LONG_PRESS_RESET;
            double_click_reg <= DOUBLE_CLICK_RESET;
            display_flip_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_LONG_PRESS:   long_press_reg   <= pwdata[15:0];
                REG_DOUBLE_CLICK: double_click_reg <= pwdata[15:0];
                REG_DISPLAY_FLIP: display_flip_reg <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_LONG_PRESS:   prdata = {16'd0, long_press_reg};
            REG_DOUBLE_CLICK: prdata = {16'd0, double_click_reg};
            REG_DISPLAY_FLIP: prdata = {31'd0, display_flip_reg};
            default:          prdata = '0;
        endcase
    end

    // Output register followed by a single skid register.
    result_word_t out_word_reg;
    result_word_t skid_word_reg;
    logic         out_valid_reg;
    logic         skid_valid_reg;
    logic         out_fire;

    // Input handshake: a word is taken whenever the skid register is free.
    logic in_fire;
    logic step;
    logic clear;

    assign sample.ready = !skid_valid_reg;
    assign in_fire      = sample.valid && sample.ready;
    assign step         = in_fire && !sample.mode;
    assign clear        = in_fire && sample.mode;

    // The flip setting swaps which outer switch drives buttons 0 and 2.
    logic [NUM_BUTTONS-1:0] level;

    assign level[0] = display_flip_reg ? sample.switch_three : sample.switch_one;
    assign level[1] = sample.switch_two;
    assign level[2] = display_flip_reg ? sample.switch_one : sample.switch_three;

    event_t      evt    [NUM_BUTTONS];
    btn_status_t status [NUM_BUTTONS];

    for (genvar b = 0; b < NUM_BUTTONS; b++)
    begin : g_button
        bgc_button u_button (
            .clk             (clk),
            .rst_n           (rst_n),
            .step            (step),
            .clear           (clear),
            .level           (level[b]),
            .now             (sample.time_ms),
            .long_press_ms   (long_press_reg),
            .double_click_ms (double_click_reg),
            .evt             (evt[b]),
            .status          (status[b])
        );
    end

    // Result word assembled from the per-button events and status.
    result_word_t word_next;

    always_comb
    begin
        word_next.event_left   = evt[0];
        word_next.event_middle = evt[1];
        word_next.event_right  = evt[2];
        word_next.held_flags   = {status[2].held, status[1].held, status[0].held};
        word_next.reset_flags  = {status[2].in_reset, status[1].in_reset,
                                  status[0].in_reset};
        word_next.lock_request = status[0].busy || status[1].busy || status[2].busy;
    end

    assign out_fire = out_valid_reg && result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_word_reg <= skid_word_reg;
            end
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_word_reg <= word_next;
            end
            else
            begin
                out_word_reg <= word_next;
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.event_left   = out_word_reg.event_left;
    assign result.event_middle = out_word_reg.event_middle;
    assign result.event_right  = out_word_reg.event_right;
    assign result.held_flags   = out_word_reg.held_flags;
    assign result.reset_flags  = out_word_reg.reset_flags;
    assign result.lock_request = out_word_reg.lock_request;

    // The skid register only ever holds a word behind the output register.
    `BGC_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid word without output word")
    // A word lands in the skid register only while the output is stalled.
    `BGC_ASSERT_SAME(a_skid_on_stall, $rose(skid_valid_reg), $past(out_valid_reg && !result.ready), "skid loaded without stall")
    // A held button is beyond idle, so it must raise the lock request.
    `BGC_ASSERT_SAME(a_held_locks, out_valid_reg && (out_word_reg.held_flags != 3'b000), out_word_reg.lock_request, "held without lock request")
    // A button cannot be held and in reset at once.
    `BGC_ASSERT_SAME(a_flags_disjoint, out_valid_reg, (out_word_reg.held_flags & out_word_reg.reset_flags) == 3'b000, "held and reset flags overlap")
    // A reset order puts every button in the reset phase.
    `BGC_ASSERT_NEXT(a_reset_order, clear && !out_valid_reg, out_word_reg.reset_flags == 3'b111, "reset order not applied")

endmodule

// ===== test/button_gesture_classifier_top_tb.sv =====
// Self-checking testbench for the three-button gesture classifier top level.
`timescale 1ns / 1ps

module button_gesture_classifier_top_tb;
    import bgc_pkg::*;

    // One word on the sample channel, as the stimulus side sees it.
    typedef struct packed {
        logic        mode;
        logic        switch_one;
        logic        switch_two;
        logic        switch_three;
        logic [31:0] time_ms;
    } sample_word_t;

    // A watchdog ends the run after this many cycles without any word moving
    // on either channel. The longest legal quiet span is the receiver hold-off.
    localparam int unsigned QUIET_LIMIT    = 2000;
    localparam int unsigned HOLD_OFF_AT    = 400;
    localparam int unsigned HOLD_OFF_LEN   = 150;
    localparam int unsigned STEADY_FIRST   = 600;
    localparam int unsigned STEADY_LAST    = 750;
    localparam int unsigned REPORT_LIMIT   = 60;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bgc_sample_if sample_ch ();
    bgc_result_if result_ch ();

    button_gesture_classifier_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 clk = ~clk;

    // Words waiting to be offered, and the classification each accepted
    // word must produce, oldest first.
    sample_word_t pending_samples[$];
    result_word_t predicted_events[$];

    // Our own copy of the per-button phases, start times and registers.
    phase_t      btn_phase [3];
    logic [31:0] phase_start [3];
    logic [15:0] long_press_cfg;
    logic [15:0] double_click_cfg;
    logic        flip_cfg;

    // Stimulus generator state: the current tick and the level each switch
    // is being held at, so that random words form real press sequences.
    logic [31:0] now_ms;
    logic        switch_level [3];

    int unsigned sent_count;
    int unsigned result_count;
    int unsigned error_count;
    int unsigned report_count;
    int unsigned quiet_cycles;

    // Advances one button on one sampled level and returns its event code.
    // Differences wrap at 32 bits, and both thresholds are strict.
    function automatic event_t step_button(int unsigned b, logic level, logic [31:0] now);
        logic [31:0] elapsed;
        event_t      ev;
        elapsed = now - phase_start[b];
        ev = EV_NONE;
        if (level)
        begin
            case (btn_phase[b])
                PH_IDLE:
                begin
                    ev = EV_PRESS;
                    btn_phase[b] = PH_FIRST_DOWN;
                    phase_start[b] = now;
                end
                PH_FIRST_DOWN:
                begin
                    if (elapsed > long_press_cfg)
                    begin
                        ev = EV_LONG;
                        btn_phase[b] = PH_HELD;
                    end
                end
                PH_WAITING:
                begin
                    // A second press inside the window is a double click;
                    // a later one simply starts a new press.
                    if (elapsed < double_click_cfg)
                    begin
                        ev = EV_DOUBLE;
                        btn_phase[b] = PH_SECOND_DOWN;
                    end
                    else
                    begin
                        ev = EV_PRESS;
                        btn_phase[b] = PH_FIRST_DOWN;
                        phase_start[b] = now;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            case (btn_phase[b])
                PH_RESET:
                begin
                    btn_phase[b] = PH_IDLE;
                end
                PH_FIRST_DOWN:
                begin
                    ev = EV_CLICK;
                    btn_phase[b] = PH_WAITING;
                    phase_start[b] = now;
                end
                PH_WAITING:
                begin
                    if (elapsed > double_click_cfg)
                        btn_phase[b] = PH_IDLE;
                end
                PH_SECOND_DOWN:
                begin
                    btn_phase[b] = PH_IDLE;
                end
                PH_HELD:
                begin
                    ev = EV_RELEASED;
                    btn_phase[b] = PH_IDLE;
                end
                default:
                begin
                end
            endcase
        end
        return ev;
    endfunction

    // Applies one accepted word to the button model and returns the result
    // word it must cause. The flags reflect the phases after the update.
    function automatic result_word_t classify_sample(sample_word_t w);
        result_word_t r;
        logic         left_level;
        logic         right_level;
        r = '0;
        if (w.mode)
        begin
            // A reset order only moves the phases; start times stay.
            for (int b = 0; b < 3; b++)
                btn_phase[b] = PH_RESET;
        end
        else
        begin
            left_level  = flip_cfg ? w.switch_three : w.switch_one;
            right_level = flip_cfg ? w.switch_one : w.switch_three;
            r.event_left   = step_button(0, left_level, w.time_ms);
            r.event_middle = step_button(1, w.switch_two, w.time_ms);
            r.event_right  = step_button(2, right_level, w.time_ms);
        end
        for (int b = 0; b < 3; b++)
        begin
            r.held_flags[b]  = (btn_phase[b] == PH_HELD);
            r.reset_flags[b] = (btn_phase[b] == PH_RESET);
            if (btn_phase[b] > PH_IDLE)
                r.lock_request = 1'b1;
        end
        return r;
    endfunction

    task automatic push_sample(logic m, logic s1, logic s2, logic s3, logic [31:0] t);
        sample_word_t w;
        w.mode         = m;
        w.switch_one   = s1;
        w.switch_two   = s2;
        w.switch_three = s3;
        w.time_ms      = t;
        pending_samples.push_back(w);
    endtask

    // Queues random words. Most are press sequences whose time steps land
    // near the current thresholds; a few are reset orders, scrambled levels
    // or arbitrary jumps of the tick.
    task automatic push_random(int unsigned count);
        int unsigned span;
        int unsigned pick;
        logic [31:0] stride;
        for (int unsigned i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 3)
            begin
                push_sample(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)),
                            1'($urandom_range(1)), $urandom());
            end
            else
            begin
                for (int b = 0; b < 3; b++)
                begin
                    if ($urandom_range(99) < 28)
                        switch_level[b] = ~switch_level[b];
                end
                if ($urandom_range(99) < 5)
                begin
                    for (int b = 0; b < 3; b++)
                        switch_level[b] = 1'($urandom_range(1));
                end
                span = $urandom_range(1) ? long_press_cfg : double_click_cfg;
                pick = $urandom_range(9);
                if (pick <= 3)
                    stride = $urandom_range(span / 2 + 1);
                else if (pick <= 6)
                    stride = span + $urandom_range(4) - 2;
                else if (pick == 7)
                    stride = $urandom_range(2 * span + 10);
                else if (pick == 8)
                    stride = '0;
                else
                    stride = $urandom();
                now_ms = now_ms + stride;
                push_sample(1'b0, switch_level[0], switch_level[1], switch_level[2], now_ms);
            end
        end
    endtask

    // Holds the sender until every queued word has been taken and every
    // predicted result has come back, so the block is idle.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_samples.size() != 0 || sample_ch.valid || predicted_events.size() != 0);
    endtask

    // APB write: a setup cycle, then an access cycle; the register takes the
    // value at the edge that closes the access cycle.
    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_LONG_PRESS:   long_press_cfg   = value[15:0];
            REG_DOUBLE_CLICK: double_click_cfg = value[15:0];
            REG_DISPLAY_FLIP: flip_cfg         = value[0];
            default:
            begin
            end
        endcase
    endtask

    task automatic set_timing(logic [15:0] long_ms, logic [15:0] double_ms, logic flip);
        write_reg(REG_LONG_PRESS, {16'd0, long_ms});
        write_reg(REG_DOUBLE_CLICK, {16'd0, double_ms});
        write_reg(REG_DISPLAY_FLIP, {31'd0, flip});
    endtask

    task automatic check_field(string name, logic [2:0] want, logic [2:0] got);
        if (want !== got)
        begin
            error_count++;
            if (report_count < REPORT_LIMIT)
            begin
                report_count++;
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        end
    endtask

    // Sample driver. At each edge it first records a word that the block
    // has just taken, then decides what to offer next. A word that was not
    // taken stays on the bus untouched. Outside the steady window the sender
    // leaves about a third of the cycles empty.
    always @(posedge clk or negedge rst_n)
    begin : drive_samples
        sample_word_t taken;
        sample_word_t next_word;
        logic         steady;
        if (!rst_n)
        begin
            sample_ch.valid        <= 1'b0;
            sample_ch.mode         <= 1'b0;
            sample_ch.switch_one   <= 1'b0;
            sample_ch.switch_two   <= 1'b0;
            sample_ch.switch_three <= 1'b0;
            sample_ch.time_ms      <= '0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                taken.mode         = sample_ch.mode;
                taken.switch_one   = sample_ch.switch_one;
                taken.switch_two   = sample_ch.switch_two;
                taken.switch_three = sample_ch.switch_three;
                taken.time_ms      = sample_ch.time_ms;
                predicted_events.push_back(classify_sample(taken));
                sent_count++;
            end
            if (!sample_ch.valid || sample_ch.ready)
            begin
                steady = (sent_count >= STEADY_FIRST && sent_count < STEADY_LAST);
                if (pending_samples.size() != 0 && (steady || $urandom_range(99) >= 35))
                begin
                    next_word = pending_samples.pop_front();
                    sample_ch.valid        <= 1'b1;
                    sample_ch.mode         <= next_word.mode;
                    sample_ch.switch_one   <= next_word.switch_one;
                    sample_ch.switch_two   <= next_word.switch_two;
                    sample_ch.switch_three <= next_word.switch_three;
                    sample_ch.time_ms      <= next_word.time_ms;
                end
                else
                begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. Each word taken is compared field by field with the
    // oldest prediction. Once, after HOLD_OFF_AT results, the receiver keeps
    // ready low for a long stretch so that the output and skid registers
    // fill and the block has to push back on the sample channel.
    always @(posedge clk or negedge rst_n)
    begin : watch_results
        result_word_t want;
        int unsigned  hold_left;
        logic         steady;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                result_count++;
                if (predicted_events.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result word with nothing predicted, expected none, got %h",
                             $time, {result_ch.event_left, result_ch.event_middle,
                                     result_ch.event_right, result_ch.held_flags,
                                     result_ch.reset_flags, result_ch.lock_request});
                end
                else
                begin
                    want = predicted_events.pop_front();
                    check_field("event_left", want.event_left, result_ch.event_left);
                    check_field("event_middle", want.event_middle, result_ch.event_middle);
                    check_field("event_right", want.event_right, result_ch.event_right);
                    check_field("held_flags", want.held_flags, result_ch.held_flags);
                    check_field("reset_flags", want.reset_flags, result_ch.reset_flags);
                    check_field("lock_request", {2'b00, want.lock_request},
                                {2'b00, result_ch.lock_request});
                end
                if (result_count == HOLD_OFF_AT)
                    hold_left = HOLD_OFF_LEN;
            end
            steady = (result_count >= STEADY_FIRST && result_count < STEADY_LAST);
            if (hold_left != 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= steady || ($urandom_range(99) >= 35);
            end
        end
    end

    // Watchdog: a run that stops moving words is a failure.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        // Every input is known from time zero, before reset releases.
        rst_n                  = 1'b0;
        sample_ch.valid        = 1'b0;
        sample_ch.mode         = 1'b0;
        sample_ch.switch_one   = 1'b0;
        sample_ch.switch_two   = 1'b0;
        sample_ch.switch_three = 1'b0;
        sample_ch.time_ms      = '0;
        result_ch.ready        = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        sent_count             = 0;
        result_count           = 0;
        error_count            = 0;
        report_count           = 0;
        quiet_cycles           = 0;
        long_press_cfg         = LONG_PRESS_RESET;
        double_click_cfg       = DOUBLE_CLICK_RESET;
        flip_cfg               = 1'b0;
        for (int b = 0; b < 3; b++)
        begin
            btn_phase[b]    = PH_IDLE;
            phase_start[b]  = '0;
            switch_level[b] = 1'b0;
        end
        now_ms = $urandom();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words under the reset defaults (long press 1000 ms,
        // double click 300 ms, no flip). A released sample in idle does
        // nothing; then a long press on the left button, exactly at the
        // threshold and then just past it, with a pressed sample in
        // the held phase ignored before the release.
        push_sample(1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
        push_sample(1'b0, 1'b1, 1'b0, 1'b0, 32'd10);
        push_sample(1'b0, 1'b1, 1'b0, 1'b0, 32'd500);
        push_sample(1'b0, 1'b1, 1'b0, 1'b0, 32'd1010);
        push_sample(1'b0, 1'b1, 1'b0, 1'b0, 32'd1011);
        push_sample(1'b0, 1'b1, 1'b0, 1'b0, 32'd5000);
        push_sample(1'b0, 1'b0, 1'b0, 1'b0, 32'd5001);
        // Middle button: click, then a double click one tick inside the
        // window, a pressed sample ignored in second down, and the release.
        push_sample(1'b0, 1'b0, 1'b1, 1'b0, 32'd6000);
        push_sample(1'b0, 1'b0, 1'b0, 1'b0, 32'd6100);
        push_sample(1'b0, 1'b0, 1'b1, 1'b0, 32'd6399);
        push_sample(1'b0, 1'b0, 1'b1, 1'b0, 32'd6500);
        push_sample(1'b0, 1'b0, 1'b0, 1'b0, 32'd6600);
        // Right button: click; exactly at the window edge a release keeps it
        // waiting and a press counts as a fresh press. A second click then
        // expires one tick past the window.
        push_sample(1'b0, 1'b0, 1'b0, 1'b1, 32'd7000);
        push_sample(1'b0, 1'b0, 1'b0, 1'b0, 32'd7050);
        push_sample(1'b0, 1'b0, 1'b0, 1'b0, 32'd7350);
        push_sample(1'b0, 1'b0, 1'b0, 1'b1, 32'd7350);
        push_sample(1'b0, 1'b0, 1'b0, 1'b0, 32'd7400);
        push_sample(1'b0, 1'b0, 1'b0, 1'b0, 32'd7701);
        // Reset order; pressed samples keep the buttons in reset, a released
        // one brings them back to idle. Then a long press of all three
        // across the wrap of the tick, and the release.
        push_sample(1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
        push_sample(1'b0, 1'b1, 1'b1, 1'b1, 32'h0000_0000);
        push_sample(1'b0, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFF0);
        push_sample(1'b0, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFF0);
        push_sample(1'b0, 1'b1, 1'b1, 1'b1, 32'h0000_0400);
        push_sample(1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0401);
        push_random(200);

        // Each later phase starts from an idle block with new settings,
        // covering both extremes of the thresholds and both flip settings.
        wait_drained();
        set_timing(16'd0, 16'd0, 1'b1);
        push_random(200);

        wait_drained();
        set_timing(16'hFFFF, 16'hFFFF, 1'b0);
        push_random(150);

        wait_drained();
        set_timing(16'd40, 16'd25, 1'b1);
        push_random(250);

        wait_drained();
        set_timing(16'd12, 16'd200, 1'b0);
        push_random(230);

        // After draining, extra edges catch any stray word.
        wait_drained();
        repeat (5) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
